[src/assert_macros.svh]
// assertion macros for the hash rtl, included by shf_mix
// clocked on i_clk; ASSERT_CLK is disabled while i_rst_n is low, ASSERT_CLK_ALWAYS is not
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, disabled during reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// concurrent check that also holds during reset
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

[src/shf_pkg.sv]
// package for the superfasthash stream block: widths, stage struct, mix and avalanche functions
// no dependencies
`timescale 1ns / 1ps

package shf_pkg;

    localparam int unsigned HASH_W  = 32;
    localparam int unsigned COUNT_W = 3;

    typedef logic [HASH_W-1:0]  t_word;
    typedef logic [COUNT_W-1:0] t_count;

    // finished message hash handed from the mix stage to the avalanche stage
    typedef struct packed {
        logic  valid;
        t_word hash;
    } t_fin;

    function automatic t_word lo16(input t_word w);
        return {16'd0, w[15:0]};
    endfunction

    function automatic t_word mix_full(input t_word h_in, input t_word w);
        t_word h;
        t_word t;
        h = h_in + lo16(w);
        t = ({16'd0, w[31:16]} << 11) ^ h;
        h = (h << 16) ^ t;
        h = h + (h >> 11);
        return h;
    endfunction

    function automatic t_word mix_tail(input t_word h_in, input t_word w, input t_count n);
        t_word h;
        h = h_in;
        case (n)
            3'd3: begin
                h = h + lo16(w);
                h = h ^ (h << 16);
                h = h ^ ({24'd0, w[23:16]} << 18);
                h = h + (h >> 11);
            end
            3'd2: begin
                h = h + lo16(w);
                h = h ^ (h << 11);
                h = h + (h >> 17);
            end
            3'd1: begin
                h = h + {24'd0, w[7:0]};
                h = h ^ (h << 10);
                h = h + (h >> 1);
            end
            default: h = h_in;
        endcase
        return h;
    endfunction

    // counts of four and above saturate to a full round
    function automatic t_word mix_item(input t_word h, input t_word w, input t_count n);
        t_word r;
        case (n) inside
            [3'd4:3'd7]: r = mix_full(h, w);
            default:     r = mix_tail(h, w, n);
        endcase
        return r;
    endfunction

    function automatic t_word avalanche(input t_word h_in);
        t_word h;
        h = h_in;
        h = h ^ (h << 3);
        h = h + (h >> 5);
        h = h ^ (h << 4);
        h = h + (h >> 17);
        h = h ^ (h << 25);
        h = h + (h >> 6);
        return h;
    endfunction

endpackage

[src/superfasthash_stream.sv]
// superfasthash stream engine, top level
// depends on shf_pkg, shf_mix and shf_aval
//
// usage:
//   slave channel s_axis_* carries message words, up to four bytes each,
//   first byte in tdata[7:0], valid byte count in tdata[34:32] (4 and above
//   is a full round). tlast marks the final word of a message.
//   master channel m_axis_* carries one 32-bit digest per message.
//   the running hash starts at zero; after the last word is mixed the hash
//   is avalanched, sent out and cleared for the next message.
// path: the last word's transaction loads the input register, the mix stage writes the
//   finish register, then the avalanche/output register holds the digest.
// throughput: one word per cycle while s_axis_tready is high, set by the combinational mix
//   round that feeds the running hash register.
// reset: synchronous active-low i_rst_n clears all valid flags and the hash.
// a stall on m_axis_tready holds the digest; words keep flowing while the
//   finish register can still take one more finished message, then the next
//   last word waits in the input register and s_axis_tready drops.
`timescale 1ns / 1ps

module superfasthash_stream (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [31:0] data_word, [34:32] byte_count, [39:35] zero
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [31:0] digest
);
    import shf_pkg::*;

    t_fin fin;
    logic fin_ready;

    shf_mix u_mix (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_data_word  (s_axis_tdata[31:0]),
        .i_byte_count (s_axis_tdata[34:32]),
        .i_last       (s_axis_tlast),
        .i_fin_ready  (fin_ready),
        .o_fin        (fin)
    );

    shf_aval u_aval (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fin       (fin),
        .o_fin_ready (fin_ready),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_digest    (m_axis_tdata)
    );

endmodule

[src/shf_mix.sv]
// input register, running hash, per-word mix round and finish register
// depends on shf_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module shf_mix (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  shf_pkg::t_word       i_data_word,
    input  shf_pkg::t_count      i_byte_count,
    input  logic                 i_last,
    input  logic                 i_fin_ready,
    output shf_pkg::t_fin        o_fin
);
    import shf_pkg::*;

    logic   r_in_valid;
    t_word  r_in_word;
    t_count r_in_count;
    logic   r_in_last;
    t_word  r_hash;
    logic   r_fin_valid;
    t_word  r_fin_hash;

    logic   in_move;
    logic   fin_ready;
    t_word  mix_val;

    assign fin_ready = !r_fin_valid || i_fin_ready;
    // a last word can only leave when the finish stage has room
    assign in_move   = r_in_valid && (!r_in_last || fin_ready);
    assign o_ready   = !r_in_valid || in_move;
    assign mix_val   = mix_item(r_hash, r_in_word, r_in_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_word  <= i_data_word;
            r_in_count <= i_byte_count;
            r_in_last  <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= '0;
        end else if (in_move) begin
            r_hash <= r_in_last ? '0 : mix_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (fin_ready) begin
            r_fin_valid <= in_move && r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_ready && in_move && r_in_last) begin
            r_fin_hash <= mix_val;
        end
    end

    assign o_fin.valid = r_fin_valid;
    assign o_fin.hash  = r_fin_hash;

    `ASSERT_CLK(a_hash_clear_after_last, (in_move && r_in_last) |=> (r_hash == '0),
        "running hash not cleared after last word")
    `ASSERT_CLK(a_fin_from_last, $rose(r_fin_valid) |-> $past(in_move && r_in_last),
        "finish stage loaded without a last word")
    `ASSERT_CLK(a_fin_hold, (r_fin_valid && !i_fin_ready) |=> (r_fin_valid && $stable(r_fin_hash)),
        "stalled finish stage changed")
    `ASSERT_CLK(a_in_hold, (r_in_valid && !in_move) |=> (r_in_valid && $stable(r_in_word)),
        "stalled input word dropped")

endmodule

[src/shf_aval.sv]
// avalanche of a finished hash and the output register
// depends on shf_pkg
`timescale 1ns / 1ps

module shf_aval (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  shf_pkg::t_fin   i_fin,
    output logic            o_fin_ready,
    output logic            o_valid,
    input  logic            i_ready,
    output shf_pkg::t_word  o_digest
);
    import shf_pkg::*;

    logic  r_out_valid;
    t_word r_out_digest;

    assign o_fin_ready = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_fin_ready) begin
            r_out_valid <= i_fin.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_fin_ready && i_fin.valid) begin
            r_out_digest <= avalanche(i_fin.hash);
        end
    end

    assign o_valid  = r_out_valid;
    assign o_digest = r_out_digest;

endmodule

[sim/superfasthash_stream_tb.sv]
// testbench for superfasthash_stream: streams message words, predicts each digest and checks it
// depends on shf_pkg and the superfasthash_stream rtl; a small scoreboard class holds the prediction
`timescale 1ns / 1ps

module superfasthash_stream_tb;

    import shf_pkg::t_word;
    import shf_pkg::t_count;

    localparam t_count BYTES_NONE = 3'd0;
    localparam t_count BYTES_1    = 3'd1;
    localparam t_count BYTES_2    = 3'd2;
    localparam t_count BYTES_3    = 3'd3;
    localparam t_count BYTES_FULL = 3'd4;
    localparam t_count BYTES_MAX  = 3'd7;

    localparam int unsigned RANDOM_WORDS   = 1150;
    localparam int unsigned QUIET_WORDS    = 100;
    localparam int unsigned RX_LONG_HOLD   = 80;
    localparam int unsigned PIPE_LATENCY   = 3;
    localparam int unsigned WATCHDOG_LIMIT = 500;

    // running hash predictor and store of digests still owed by the block
    class digest_scoreboard;
        t_word       running_hash;
        t_word       digest_q[$];
        int unsigned mismatches;
        int unsigned digests_checked;
        int unsigned words_seen;

        function new();
            running_hash    = '0;
            mismatches      = 0;
            digests_checked = 0;
            words_seen      = 0;
        endfunction

        function t_word full_round(t_word h_in, t_word w);
            t_word h;
            t_word t;
            h = h_in + {16'd0, w[15:0]};
            t = ({16'd0, w[31:16]} << 11) ^ h;
            h = (h << 16) ^ t;
            h = h + (h >> 11);
            return h;
        endfunction

        function t_word tail_round(t_word h_in, t_word w, t_count n);
            t_word h;
            h = h_in;
            if (n == BYTES_3) begin
                h = h + {16'd0, w[15:0]};
                h = h ^ (h << 16);
                h = h ^ ({24'd0, w[23:16]} << 18);
                h = h + (h >> 11);
            end else if (n == BYTES_2) begin
                h = h + {16'd0, w[15:0]};
                h = h ^ (h << 11);
                h = h + (h >> 17);
            end else if (n == BYTES_1) begin
                h = h + {24'd0, w[7:0]};
                h = h ^ (h << 10);
                h = h + (h >> 1);
            end
            return h;
        endfunction

        function t_word finish_hash(t_word h_in);
            t_word h;
            h = h_in;
            h = h ^ (h << 3);
            h = h + (h >> 5);
            h = h ^ (h << 4);
            h = h + (h >> 17);
            h = h ^ (h << 25);
            h = h + (h >> 6);
            return h;
        endfunction

        function void note_word(t_word data, t_count count, logic last);
            words_seen++;
            // counts of four and above take the full round
            if (count >= BYTES_FULL)
                running_hash = full_round(running_hash, data);
            else
                running_hash = tail_round(running_hash, data, count);
            if (last) begin
                digest_q.push_back(finish_hash(running_hash));
                running_hash = '0;
            end
        endfunction

        function void check_digest(t_word got);
            t_word want;
            if (digest_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected digest %08h, none was due", $time, got);
            end else begin
                want = digest_q.pop_front();
                digests_checked++;
                if (got !== want) begin
                    mismatches++;
                    $display("%0t: digest mismatch, expected %08h, actual %08h",
                             $time, want, got);
                end
            end
        endfunction

        function int unsigned pending();
            return digest_q.size();
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;   // [31:0] data_word, [34:32] byte_count, [39:35] zero
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // [31:0] digest

    digest_scoreboard sb = new();

    bit          tx_idle_on    = 1'b1;
    bit          rx_stall_on   = 1'b1;
    bit          rx_hold_req   = 1'b0;
    int unsigned rx_stall_left = 0;
    int unsigned words_sent    = 0;
    int unsigned long_holds    = 0;
    int unsigned drains        = 0;

    superfasthash_stream u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // digest receiver: short random stalls, plus one long hold on request
    always @(posedge i_clk) begin
        if (rx_hold_req) begin
            rx_hold_req   = 1'b0;
            rx_stall_left = RX_LONG_HOLD;
        end
        if (rx_stall_left != 0) begin
            m_axis_tready <= 1'b0;
            rx_stall_left--;
        end else if (rx_stall_on && $urandom_range(0, 4) == 0) begin
            m_axis_tready <= 1'b0;
            rx_stall_left = $urandom_range(0, 4);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // transaction monitor on both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_word(s_axis_tdata[31:0], s_axis_tdata[34:32], s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_digest(m_axis_tdata);
        end
    end

    initial begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: timeout, no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
    end

    task automatic send_word(input t_word data, input t_count count, input logic last);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, count, data};
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        words_sent++;
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    // full words followed by a closing word with a random byte count
    task automatic send_message(input int unsigned n_full);
        t_count tail;
        for (int unsigned k = 0; k < n_full; k++)
            send_word($urandom, BYTES_FULL, 1'b0);
        tail = ($urandom_range(0, 9) < 8) ? t_count'($urandom_range(0, 4))
                                          : t_count'($urandom_range(5, 7));
        send_word($urandom, tail, 1'b1);
    endtask

    task automatic wait_digests_done();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        int unsigned n_full;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, every byte count, saturated counts, empty closing word
        send_word(32'h0000_0000, BYTES_FULL, 1'b0);
        send_word(32'hFFFF_FFFF, BYTES_FULL, 1'b1);
        send_word(32'hFFFF_FFFF, BYTES_NONE, 1'b1);
        send_word(32'hFFFF_FFFF, BYTES_3,    1'b1);
        send_word(32'h8080_8080, BYTES_2,    1'b1);
        send_word(32'h0000_00FF, BYTES_1,    1'b1);
        send_word(32'h1234_5678, 3'd5,       1'b0);
        send_word(32'h9ABC_DEF0, 3'd6,       1'b0);
        send_word(32'hFFFF_FFFF, BYTES_MAX,  1'b1);
        send_word(32'hFFFF_FF80, BYTES_1,    1'b0);
        send_word(32'hFFFF_FFFF, BYTES_NONE, 1'b0);
        send_word(32'h0000_0000, BYTES_NONE, 1'b1);
        send_word(32'hDEAD_BEEF, BYTES_FULL, 1'b0);
        send_word(32'hDEAD_BEEF, BYTES_FULL, 1'b0);
        send_word(32'hCAFE_F00D, BYTES_3,    1'b1);
        send_word(32'h7FFF_FFFF, BYTES_2,    1'b0);
        send_word(32'h8000_0000, BYTES_1,    1'b1);
        send_word(32'h00FF_8000, BYTES_3,    1'b1);
        wait_digests_done();
        drains++;

        // random: mostly well-formed messages, some loose words
        while (words_sent < RANDOM_WORDS) begin
            if (long_holds == 0 && words_sent > 400) begin
                // hold the digest side while single-word messages keep coming
                long_holds++;
                tx_idle_on  = 1'b0;
                rx_hold_req = 1'b1;
                repeat (10) send_word($urandom, t_count'($urandom_range(0, 7)), 1'b1);
                tx_idle_on  = 1'b1;
            end else if (drains == 1 && words_sent > 700) begin
                wait_digests_done();
                drains++;
            end else if (words_sent > RANDOM_WORDS - QUIET_WORDS) begin
                tx_idle_on  = 1'b0;
                rx_stall_on = 1'b0;
            end

            if ($urandom_range(0, 99) < 85) begin
                n_full = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 12)
                                                     : $urandom_range(0, 3);
                send_message(n_full);
            end else begin
                send_word($urandom, t_count'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            end
        end

        // close any open message so its digest is checked too
        send_word($urandom, t_count'($urandom_range(0, 4)), 1'b1);
        wait_digests_done();
        repeat (PIPE_LATENCY + 5) @(posedge i_clk);

        $display("run covered %0d words and %0d digests, %0d long output holds, %0d mismatches",
                 sb.words_seen, sb.digests_checked, long_holds, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("%0d digests still owed at the end", sb.pending());
            $display("FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+src
src/shf_pkg.sv
src/shf_mix.sv
src/shf_aval.sv
src/superfasthash_stream.sv
sim/superfasthash_stream_tb.sv
